/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the ray/triangle block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define RTI_ASSERT_IMPL(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error(MSG);

// condition implies consequence in the next cycle
`define RTI_ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

/* src/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// shared types and constants of the ray/triangle intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_REGS       = 7;
  localparam int REG_IDX_BITS   = 3;

  // configuration register map
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_EPSILON  = 3'd6
  } reg_idx_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_PARALLEL = 3'd1,
    ST_U_OUT    = 3'd2,
    ST_V_OUT    = 3'd3,
    ST_BEHIND   = 3'd4
  } status_t;

  // control that travels with each beat through classify and divide
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    sat;
    logic    tzero;
  } rti_ctl_t;

endpackage

/* src/rti_if.sv */
// ----------------------------------------------------------------------------
// rti_if
// triangle input channel and intersection result channel
// ----------------------------------------------------------------------------
interface rti_tri_if import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] anchor_x;
  logic signed [COORD_BITS-1:0] anchor_y;
  logic signed [COORD_BITS-1:0] anchor_z;
  logic signed [COORD_BITS-1:0] edge1_x;
  logic signed [COORD_BITS-1:0] edge1_y;
  logic signed [COORD_BITS-1:0] edge1_z;
  logic signed [COORD_BITS-1:0] edge2_x;
  logic signed [COORD_BITS-1:0] edge2_y;
  logic signed [COORD_BITS-1:0] edge2_z;

  modport source (
    output valid, anchor_x, anchor_y, anchor_z, edge1_x, edge1_y, edge1_z,
           edge2_x, edge2_y, edge2_z,
    input  ready
  );
  modport sink (
    input  valid, anchor_x, anchor_y, anchor_z, edge1_x, edge1_y, edge1_z,
           edge2_x, edge2_y, edge2_z,
    output ready
  );
endinterface

interface rti_res_if import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] distance;
  logic [2:0]                   status;

  modport source (output valid, hit, distance, status, input ready);
  modport sink (input valid, hit, distance, status, output ready);
endinterface

/* src/ray_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// ray/triangle intersection test of one configured ray against a triangle
// stream, with APB register port
// ----------------------------------------------------------------------------
// One triangle is taken every cycle unless the output buffer is full, and
// one result comes out per triangle, in order. A triangle passes six stages
// of cross and dot products, two of classification, COORD_BITS - 1 stages of
// the restoring divider (one quotient bit each), the result register and the
// output register. The divider depth sets the latency. A two-entry output
// buffer lets the pipeline keep taking triangles while one result waits; the
// pipeline stalls as a whole only when both entries are full. Registers are
// to be written over APB only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_triangle_intersect import rti_pkg::*; #(
  parameter  int COORD_BITS   = COORD_BITS_DEF,
  parameter  int FRAC_BITS    = FRAC_BITS_DEF,
  localparam int BYTE_LOG     = (COORD_BITS > 32) ? 3 : 2,
  localparam int DATA_W       = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_W       = REG_IDX_BITS + BYTE_LOG
) (
  input  logic              clk,
  input  logic              rst,
  rti_tri_if.sink           tri_in,
  rti_res_if.source         res_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CB = COORD_BITS;
  localparam int WD = 3 * COORD_BITS + 5;
  localparam int WN = WD + COORD_BITS + FRAC_BITS;

  typedef struct packed {
    logic          hit;
    logic [CB-1:0] distance;
    status_t       status;
  } res_t;

  logic [2:0][CB-1:0] origin;
  logic [2:0][CB-1:0] dir;
  logic [CB-2:0]      eps;
  reg_idx_t           reg_idx;

  logic                 advance;
  logic                 f_valid;
  logic signed [WD-1:0] f_det, f_un, f_vn, f_tn;
  rti_ctl_t             c_ctl;
  logic signed [WN-1:0] c_num, c_den;
  logic                 p_valid, p_hit;
  logic [CB-1:0]        p_dist;
  status_t              p_status;

  logic out_v, skid_v;
  res_t out_r, skid_r, pipe_r;

  // register decode
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:BYTE_LOG]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      dir    <= {CB'(1) << FRAC_BITS, {CB{1'b0}}, {CB{1'b0}}};
      eps    <= (CB-1)'(1);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ORIGIN_X: origin[0] <= pwdata[CB-1:0];
        REG_ORIGIN_Y: origin[1] <= pwdata[CB-1:0];
        REG_ORIGIN_Z: origin[2] <= pwdata[CB-1:0];
        REG_DIR_X:    dir[0]    <= pwdata[CB-1:0];
        REG_DIR_Y:    dir[1]    <= pwdata[CB-1:0];
        REG_DIR_Z:    dir[2]    <= pwdata[CB-1:0];
        REG_EPSILON:  eps       <= pwdata[CB-2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = DATA_W'(origin[0]);
      REG_ORIGIN_Y: prdata = DATA_W'(origin[1]);
      REG_ORIGIN_Z: prdata = DATA_W'(origin[2]);
      REG_DIR_X:    prdata = DATA_W'(dir[0]);
      REG_DIR_Y:    prdata = DATA_W'(dir[1]);
      REG_DIR_Z:    prdata = DATA_W'(dir[2]);
      REG_EPSILON:  prdata = DATA_W'(eps);
      default:      prdata = '0;
    endcase
  end

  // pipeline moves whenever the output buffer has room
  assign advance      = !skid_v;
  assign tri_in.ready = advance;

  rti_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (tri_in.valid),
    .anchor    ({tri_in.anchor_z, tri_in.anchor_y, tri_in.anchor_x}),
    .edge1     ({tri_in.edge1_z, tri_in.edge1_y, tri_in.edge1_x}),
    .edge2     ({tri_in.edge2_z, tri_in.edge2_y, tri_in.edge2_x}),
    .origin    (origin),
    .dir       (dir),
    .out_valid (f_valid),
    .det       (f_det),
    .un        (f_un),
    .vn        (f_vn),
    .tn        (f_tn)
  );

  rti_classify #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_classify (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (f_valid),
    .det      (f_det),
    .un       (f_un),
    .vn       (f_vn),
    .tn       (f_tn),
    .eps      (eps),
    .ctl_out  (c_ctl),
    .num_out  (c_num),
    .den_out  (c_den)
  );

  rti_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ctl_in       (c_ctl),
    .num_in       (c_num),
    .den_in       (c_den),
    .eps          (eps),
    .out_valid    (p_valid),
    .out_hit      (p_hit),
    .out_distance (p_dist),
    .out_status   (p_status)
  );

  assign pipe_r = '{hit: p_hit, distance: p_dist, status: p_status};

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || res_out.ready) begin
      out_v  <= skid_v || p_valid;
      skid_v <= 1'b0;
    end else if (p_valid && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || res_out.ready) begin
      out_r <= skid_v ? skid_r : pipe_r;
    end else if (p_valid && !skid_v) begin
      skid_r <= pipe_r;
    end
  end

  assign res_out.valid    = out_v;
  assign res_out.hit      = out_r.hit;
  assign res_out.distance = out_r.distance;
  assign res_out.status   = out_r.status;

  // checks
  `RTI_ASSERT_IMPL(a_hit_status, clk, rst, res_out.valid && res_out.hit, res_out.status == ST_HIT, "hit without hit status")
  `RTI_ASSERT_IMPL(a_miss_zero, clk, rst, res_out.valid && !res_out.hit, res_out.distance == '0, "nonzero distance on a miss")
  `RTI_ASSERT_IMPL(a_skid_order, clk, rst, skid_v, out_v, "skid entry full while output register empty")
  `RTI_ASSERT_NEXT(a_skid_stall, clk, rst, skid_v && out_v && !res_out.ready, skid_v && $stable(skid_r), "skid entry lost while stalled")

endmodule

/* src/rti_front.sv */
// ----------------------------------------------------------------------------
// rti_front
// six-stage datapath: s = origin - anchor, h = dir x e2, q = s x e1, then the
// exact dot products det = e1.h, un = s.h, vn = dir.q, tn = e2.q
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int WD         = 3 * COORD_BITS + 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic [2:0][COORD_BITS-1:0]   anchor,
  input  logic [2:0][COORD_BITS-1:0]   edge1,
  input  logic [2:0][COORD_BITS-1:0]   edge2,
  input  logic [2:0][COORD_BITS-1:0]   origin,
  input  logic [2:0][COORD_BITS-1:0]   dir,
  output logic                         out_valid,
  output logic signed [WD-1:0]         det,
  output logic signed [WD-1:0]         un,
  output logic signed [WD-1:0]         vn,
  output logic signed [WD-1:0]         tn
);

  localparam int CB      = COORD_BITS;
  localparam int DOT_DET = 0;
  localparam int DOT_U   = 1;
  localparam int DOT_V   = 2;
  localparam int DOT_T   = 3;

  logic v1, v2, v3, v4, v5, v6;

  logic signed [CB:0]       s1 [3];
  logic signed [CB:0]       s2 [3];
  logic signed [CB:0]       s3 [3];
  logic [2:0][CB-1:0]       e1_1, e1_2, e1_3;
  logic [2:0][CB-1:0]       e2_1, e2_2, e2_3;
  logic signed [2*CB-1:0]   hp [3][2];
  logic signed [2*CB:0]     qp [3][2];
  logic signed [2*CB:0]     h3 [3];
  logic signed [2*CB+1:0]   q3 [3];
  logic signed [CB:0]       aop [4][3];
  logic signed [2*CB+1:0]   bop [4][3];
  logic signed [2*CB+1:0]   plo [4][3];
  logic signed [2*CB+2:0]   phi [4][3];
  logic signed [WD-1:0]     term [4][3];
  logic signed [WD-1:0]     dsum [4];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: offset from anchor to ray origin
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= {origin[i][CB-1], origin[i]} - {anchor[i][CB-1], anchor[i]};
      end
      e1_1 <= edge1;
      e2_1 <= edge2;
    end
  end

  // stage 2: cross product partial products
  for (genvar gi = 0; gi < 3; gi++) begin : g_cross
    localparam int J = (gi + 1) % 3;
    localparam int K = (gi + 2) % 3;
    always_ff @(posedge clk) begin
      if (advance) begin
        hp[gi][0] <= $signed(dir[J]) * $signed(e2_1[K]);
        hp[gi][1] <= $signed(dir[K]) * $signed(e2_1[J]);
        qp[gi][0] <= s1[J] * $signed(e1_1[K]);
        qp[gi][1] <= s1[K] * $signed(e1_1[J]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2   <= s1;
      e1_2 <= e1_1;
      e2_2 <= e2_1;
    end
  end

  // stage 3: cross product differences
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        h3[i] <= {hp[i][0][2*CB-1], hp[i][0]} - {hp[i][1][2*CB-1], hp[i][1]};
        q3[i] <= {qp[i][0][2*CB], qp[i][0]} - {qp[i][1][2*CB], qp[i][1]};
      end
      s3   <= s2;
      e1_3 <= e1_2;
      e2_3 <= e2_2;
    end
  end

  // dot product operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aop[DOT_DET][i] = {e1_3[i][CB-1], e1_3[i]};
      aop[DOT_U][i]   = s3[i];
      aop[DOT_V][i]   = {dir[i][CB-1], dir[i]};
      aop[DOT_T][i]   = {e2_3[i][CB-1], e2_3[i]};
      bop[DOT_DET][i] = {h3[i][2*CB], h3[i]};
      bop[DOT_U][i]   = {h3[i][2*CB], h3[i]};
      bop[DOT_V][i]   = q3[i];
      bop[DOT_T][i]   = q3[i];
    end
  end

  // stage 4: wide operand split into low and high halves
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int d = 0; d < 4; d++) begin
        for (int i = 0; i < 3; i++) begin
          plo[d][i] <= aop[d][i] * $signed({1'b0, bop[d][i][CB-1:0]});
          phi[d][i] <= aop[d][i] * $signed(bop[d][i][2*CB+1:CB]);
        end
      end
    end
  end

  // stage 5: recombine halves
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int d = 0; d < 4; d++) begin
        for (int i = 0; i < 3; i++) begin
          term[d][i] <= ({{(WD-2*CB-3){phi[d][i][2*CB+2]}}, phi[d][i]} << CB)
                      + {{(WD-2*CB-2){plo[d][i][2*CB+1]}}, plo[d][i]};
        end
      end
    end
  end

  // stage 6: three-term sums
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int d = 0; d < 4; d++) begin
        dsum[d] <= term[d][0] + term[d][1] + term[d][2];
      end
    end
  end

  assign out_valid = v6;
  assign det       = dsum[DOT_DET];
  assign un        = dsum[DOT_U];
  assign vn        = dsum[DOT_V];
  assign tn        = dsum[DOT_T];

endmodule

/* src/rti_classify.sv */
// ----------------------------------------------------------------------------
// rti_classify
// two stages: sign fix and parallel test, then u/v range tests and the
// scaled numerator and denominator for the divider
// ----------------------------------------------------------------------------
module rti_classify import rti_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  parameter  int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int WD         = 3 * COORD_BITS + 5,
  localparam int WN         = WD + COORD_BITS + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic signed [WD-1:0]    det,
  input  logic signed [WD-1:0]    un,
  input  logic signed [WD-1:0]    vn,
  input  logic signed [WD-1:0]    tn,
  input  logic [COORD_BITS-2:0]   eps,
  output rti_ctl_t                ctl_out,
  output logic signed [WN-1:0]    num_out,
  output logic signed [WN-1:0]    den_out
);

  logic                 neg;
  logic signed [WD-1:0] absd, un_f, vn_f, tn_f;
  logic signed [WN-1:0] absd_w, eps_w;

  logic                 v1, par1;
  logic signed [WD-1:0] d1, u1, w1, t1;

  logic signed [WN-1:0] num_c, den_c;
  logic signed [WD:0]   uv_sum;
  logic                 sat_c;
  status_t              st_c;

  // sign fix so the determinant is non-negative
  always_comb begin
    neg    = det[WD-1];
    absd   = neg ? -det : det;
    un_f   = neg ? -un : un;
    vn_f   = neg ? -vn : vn;
    tn_f   = neg ? -tn : tn;
    absd_w = {{(WN-WD){absd[WD-1]}}, absd};
    eps_w  = $signed(WN'(eps) << (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      par1 <= absd_w < eps_w;
      d1   <= absd;
      u1   <= un_f;
      w1   <= vn_f;
      t1   <= tn_f;
    end
  end

  // range tests and divider operands
  always_comb begin
    uv_sum = {u1[WD-1], u1} + {w1[WD-1], w1};
    num_c  = {{(WN-WD){t1[WD-1]}}, t1} <<< FRAC_BITS;
    den_c  = {{(WN-WD){d1[WD-1]}}, d1};
    sat_c  = num_c >= (den_c <<< (COORD_BITS - 1));
    if (par1) begin
      st_c = ST_PARALLEL;
    end else if (u1 < 0 || u1 > d1) begin
      st_c = ST_U_OUT;
    end else if (w1 < 0 || uv_sum > {d1[WD-1], d1}) begin
      st_c = ST_V_OUT;
    end else begin
      st_c = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out <= '{valid: v1, status: st_c, sat: sat_c, tzero: (t1 == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num_out <= num_c;
      den_out <= den_c;
    end
  end

endmodule

/* src/rti_divider.sv */
// ----------------------------------------------------------------------------
// rti_divider
// restoring divider, one quotient bit per stage, then the behind-origin test
// and the final result register
// ----------------------------------------------------------------------------
module rti_divider import rti_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  parameter  int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int WD         = 3 * COORD_BITS + 5,
  localparam int WN         = WD + COORD_BITS + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  rti_ctl_t                ctl_in,
  input  logic signed [WN-1:0]    num_in,
  input  logic signed [WN-1:0]    den_in,
  input  logic [COORD_BITS-2:0]   eps,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [COORD_BITS-1:0]   out_distance,
  output status_t                 out_status
);

  localparam int QW = COORD_BITS - 1;

  rti_ctl_t             ctl [COORD_BITS];
  logic signed [WN-1:0] rem [COORD_BITS];
  logic signed [WN-1:0] den [COORD_BITS];
  logic [QW-1:0]        quo [COORD_BITS];

  logic                 behind;
  status_t              st_fin;
  logic [QW-1:0]        q_fin;

  assign ctl[0] = ctl_in;
  assign rem[0] = num_in;
  assign den[0] = den_in;
  assign quo[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic signed [WN-1:0] shifted;
    logic                 take;

    assign shifted = den[k] <<< B;
    assign take    = rem[k] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else if (advance) begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k+1] <= take ? rem[k] - shifted : rem[k];
        den[k+1] <= den[k];
        quo[k+1] <= quo[k] | (QW'(take) << B);
      end
    end
  end

  // t not above epsilon, from quotient and remainder
  always_comb begin
    q_fin  = quo[QW];
    behind = ctl[QW].tzero
          || (!ctl[QW].sat && (q_fin < eps || (q_fin == eps && rem[QW] <= 0)));
    st_fin = ctl[QW].status;
    if (ctl[QW].status == ST_HIT && behind) begin
      st_fin = ST_BEHIND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= st_fin;
      out_hit    <= (st_fin == ST_HIT);
      if (st_fin != ST_HIT) begin
        out_distance <= '0;
      end else if (ctl[QW].sat) begin
        out_distance <= {1'b0, {QW{1'b1}}};
      end else begin
        out_distance <= {1'b0, q_fin};
      end
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ray/triangle intersection pipeline: triangles
// go in over a bursty valid/ready channel, results are checked in order
// against a wide-integer prediction kept in a scoreboard class
// ----------------------------------------------------------------------------
module testbench;
  import rti_pkg::*;

  localparam int CW       = 32;
  localparam int FW       = 16;
  localparam int ONE      = 1 << FW;
  localparam int IDLE_MAX = 4000;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
  } triangle_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] distance;
    status_t              status;
  } isect_t;

  // expected intersections, predicted from the configured ray
  class isect_board;
    logic [CW-1:0] ray_reg [NUM_REGS];
    isect_t        pending [$];
    int            errors;

    function new();
      foreach (ray_reg[i]) ray_reg[i] = '0;
      ray_reg[REG_DIR_Z]   = ONE;
      ray_reg[REG_EPSILON] = 1;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CW-1:0] val);
      ray_reg[idx] = val;
    endfunction

    // exact integer moller-trumbore on one triangle
    function void note(triangle_t t);
      wide_t ox, oy, oz, dx, dy, dz, sx, sy, sz, hx, hy, hz, qx, qy, qz;
      wide_t e1x, e1y, e1z, e2x, e2y, e2z;
      wide_t det, un, vn, tn, eps, num;
      isect_t r;
      ox = $signed(ray_reg[REG_ORIGIN_X]);
      oy = $signed(ray_reg[REG_ORIGIN_Y]);
      oz = $signed(ray_reg[REG_ORIGIN_Z]);
      dx = $signed(ray_reg[REG_DIR_X]);
      dy = $signed(ray_reg[REG_DIR_Y]);
      dz = $signed(ray_reg[REG_DIR_Z]);
      eps = {1'b0, ray_reg[REG_EPSILON][CW-2:0]};
      e1x = t.e1x; e1y = t.e1y; e1z = t.e1z;
      e2x = t.e2x; e2y = t.e2y; e2z = t.e2z;
      sx = ox - wide_t'(t.ax);
      sy = oy - wide_t'(t.ay);
      sz = oz - wide_t'(t.az);
      hx = dy * e2z - dz * e2y;
      hy = dz * e2x - dx * e2z;
      hz = dx * e2y - dy * e2x;
      qx = sy * e1z - sz * e1y;
      qy = sz * e1x - sx * e1z;
      qz = sx * e1y - sy * e1x;
      det = e1x * hx + e1y * hy + e1z * hz;
      un  = sx * hx + sy * hy + sz * hz;
      vn  = dx * qx + dy * qy + dz * qz;
      tn  = e2x * qx + e2y * qy + e2z * qz;
      r.hit = 1'b0;
      r.distance = '0;
      if (det < 0) begin
        det = -det; un = -un; vn = -vn; tn = -tn;
      end
      num = tn <<< FW;
      if (det < (eps <<< (2 * FW))) begin
        r.status = ST_PARALLEL;
      end else if (un < 0 || un > det) begin
        r.status = ST_U_OUT;
      end else if (vn < 0 || un + vn > det) begin
        r.status = ST_V_OUT;
      end else if (num <= eps * det) begin
        r.status = ST_BEHIND;
      end else begin
        r.status = ST_HIT;
        r.hit = 1'b1;
        // a zero determinant lands here only with positive num: saturates
        if (num >= (det <<< (CW - 1))) r.distance = {1'b0, {(CW-1){1'b1}}};
        else r.distance = CW'(num / det);
      end
      pending = {pending, r};
    endfunction

    task report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check(logic hit, logic signed [CW-1:0] distance, logic [2:0] status);
      isect_t w;
      if (pending.size() == 0) begin
        report("unexpected result beat", {29'b0, status}, '0);
        return;
      end
      w = pending.pop_front();
      if (hit !== w.hit) report("hit", CW'(hit), CW'(w.hit));
      if (distance !== w.distance) report("distance", distance, w.distance);
      if (status !== w.status) report("status", CW'(status), CW'(w.status));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        hold_off;
  int          idle_cycles = 0;
  int          burst_left;
  isect_board  board;

  rti_tri_if tri_ch ();
  rti_res_if res_ch ();

  ray_triangle_intersect dut (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_ch.sink),
    .res_out (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // accepted beats on both channels, plus the stall watchdog
  always @(posedge clk) begin
    triangle_t t;
    logic      moved;
    if (!rst) begin
      moved = 1'b0;
      if (tri_ch.valid && tri_ch.ready) begin
        t.ax = tri_ch.anchor_x; t.ay = tri_ch.anchor_y; t.az = tri_ch.anchor_z;
        t.e1x = tri_ch.edge1_x; t.e1y = tri_ch.edge1_y; t.e1z = tri_ch.edge1_z;
        t.e2x = tri_ch.edge2_x; t.e2y = tri_ch.edge2_y; t.e2z = tri_ch.edge2_z;
        board.note(t);
        moved = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        board.check(res_ch.hit, res_ch.distance, res_ch.status);
        moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles == IDLE_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern: open stretches, random stalls, optional hold-off
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else if (hold_off) res_ch.ready <= 1'b0;
    else if (($urandom % 64) < 36) res_ch.ready <= 1'b1;
    else res_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, eps);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_EPSILON, eps);
  endtask

  // one triangle beat, with bursts and gaps in front of it
  task automatic send_tri(triangle_t t);
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        tri_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    tri_ch.valid    <= 1'b1;
    tri_ch.anchor_x <= t.ax;  tri_ch.anchor_y <= t.ay;  tri_ch.anchor_z <= t.az;
    tri_ch.edge1_x  <= t.e1x; tri_ch.edge1_y  <= t.e1y; tri_ch.edge1_z  <= t.e1z;
    tri_ch.edge2_x  <= t.e2x; tri_ch.edge2_y  <= t.e2y; tri_ch.edge2_z  <= t.e2z;
    do begin
      @(negedge clk);
      taken = tri_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    tri_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic triangle_t mk_tri(int ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z);
    triangle_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.e1x = e1x; t.e1y = e1y; t.e1z = e1z;
    t.e2x = e2x; t.e2y = e2y; t.e2z = e2z;
    return t;
  endfunction

  function automatic logic [31:0] small_val();
    return $urandom_range(0, 8 * ONE) - 4 * ONE;
  endfunction

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // triangle aimed at the ray: anchor placed so the hit lands at chosen u, v, t
  function automatic triangle_t aimed_tri();
    triangle_t t;
    longint u, v, k, p;
    logic signed [31:0] e1 [3], e2 [3];
    foreach (e1[i]) begin
      e1[i] = small_val();
      e2[i] = small_val();
    end
    u = $urandom_range(0, ONE);
    v = $urandom_range(0, ONE);
    k = $signed($urandom_range(0, 5 * ONE)) - ONE;
    t.e1x = e1[0]; t.e1y = e1[1]; t.e1z = e1[2];
    t.e2x = e2[0]; t.e2y = e2[1]; t.e2z = e2[2];
    for (int i = 0; i < 3; i++) begin
      p = longint'($signed(board.ray_reg[i]))
        + ((k * longint'($signed(board.ray_reg[3 + i]))) >>> FW)
        - ((u * e1[i]) >>> FW) - ((v * e2[i]) >>> FW);
      if (i == 0) t.ax = p[31:0];
      else if (i == 1) t.ay = p[31:0];
      else t.az = p[31:0];
    end
    return t;
  endfunction

  function automatic triangle_t random_tri();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return aimed_tri();
    if (sel < 85) return mk_tri(small_val(), small_val(), small_val(), small_val(),
                                small_val(), small_val(), small_val(), small_val(),
                                small_val());
    if (sel < 95) return mk_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
    return mk_tri(edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
                  edge_val(), edge_val(), edge_val(), edge_val());
  endfunction

  task automatic random_run(int count);
    repeat (count) send_tri(random_tri());
  endtask

  // stimulus
  initial begin
    board = new();
    tri_ch.valid <= 1'b0;
    tri_ch.anchor_x <= '0; tri_ch.anchor_y <= '0; tri_ch.anchor_z <= '0;
    tri_ch.edge1_x <= '0;  tri_ch.edge1_y <= '0;  tri_ch.edge1_z <= '0;
    tri_ch.edge2_x <= '0;  tri_ch.edge2_y <= '0;  tri_ch.edge2_z <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    hold_off <= 1'b0;
    burst_left = 0;
    @(negedge rst);

    // directed cases under the reset ray (origin 0, direction +z)
    send_tri(mk_tri(-ONE, -ONE, 5 * ONE, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(-ONE, -ONE, 5 * ONE, 0, 4 * ONE, 0, 4 * ONE, 0, 0));
    send_tri(mk_tri(-ONE, -ONE, -5 * ONE, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(-ONE, -ONE, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(ONE, -ONE, 5 * ONE, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(-ONE, ONE, 5 * ONE, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(-3 * ONE, -3 * ONE, 5 * ONE, 4 * ONE, 0, 0, 0, 4 * ONE, 0));
    send_tri(mk_tri(0, 0, 5 * ONE, 0, 0, 2 * ONE, 0, 0, ONE));
    send_tri(mk_tri(-1, -1, 32'h7fff0000, 2, 0, 0, 0, 2, 0));
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(mk_tri('1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_tri(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff));
    send_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000));
    send_tri(mk_tri(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0,
                    0, 32'h7fffffff, 0));
    send_tri(mk_tri(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                    32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                    32'h55555555));
    random_run(100);
    drain();

    // small random ray; once mid-phase wait until every result is back
    set_ray(small_val(), small_val(), small_val(), small_val(), small_val(),
            small_val(), 1);
    random_run(70);
    drain();
    random_run(70);
    drain();

    // huge epsilon with the ignored top bit set; receiver holds off for a while
    set_ray(0, 0, 0, 0, 0, ONE, 32'hffffffff);
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_run(120);
    join
    drain();

    // zero direction and zero epsilon: zero determinant that can still hit
    set_ray(small_val(), small_val(), small_val(), 0, 0, 0, 0);
    send_tri(mk_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_tri(mk_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    random_run(100);
    drain();

    // extreme ray
    set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 0);
    random_run(100);
    drain();

    // random ray and tiny epsilon, then the largest legal epsilon
    set_ray(small_val(), small_val(), small_val(), small_val(), small_val(),
            small_val(), 32'h100);
    random_run(130);
    drain();
    set_ray(small_val(), small_val(), small_val(), small_val(), small_val(),
            small_val(), 32'h7fffffff);
    random_run(80);
    drain();

    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* ray_triangle_intersect.f */
+incdir+src
src/rti_pkg.sv
src/rti_if.sv
src/rti_front.sv
src/rti_classify.sv
src/rti_divider.sv
src/ray_triangle_intersect.sv
tb/testbench.sv
